>>> hw/rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the stream pattern matcher
// widths of the fixed fields, register codes and the control structs
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 48;
    localparam int LEN_W     = 6;
    localparam int WORD_W    = 64;
    localparam int PAT_WORDS = 4;
    localparam int PAT_BYTES = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } spm_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0]                  pattern_length;
        logic [PAT_WORDS-1:0][WORD_W-1:0]  pattern_word;
    } spm_cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } spm_cell_ctl_t;

    // byte j of the pattern, byte k of a word in bits 8k up
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PAT_WORDS-1:0][WORD_W-1:0] words,
        input logic [4:0]                        j
    );
        logic [WORD_W-1:0] w;
        w = words[j[4:3]];
        return w[{j[2:0], 3'b000} +: BYTE_W];
    endfunction

endpackage

>>> hw/rtl/spm_in_if.sv
// ----------------------------------------------------------------------------
// spm_in_if: byte stream channel
// one searched byte and its end-of-stream mark per item
// ----------------------------------------------------------------------------
interface spm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

>>> hw/rtl/spm_out_if.sv
// ----------------------------------------------------------------------------
// spm_out_if: match result channel
// match flag, start offset and running match count per item
// ----------------------------------------------------------------------------
interface spm_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [47:0] match_offset;
    logic [47:0] match_total;

    modport source (output valid, output match_found, output match_offset,
                    output match_total, input ready);
    modport sink   (input valid, input match_found, input match_offset,
                    input match_total, output ready);
endinterface

>>> hw/rtl/spm_cfg_if.sv
// ----------------------------------------------------------------------------
// spm_cfg_if: configuration write channel
// register index and write data per write
// ----------------------------------------------------------------------------
interface spm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/spm_cfg.sv
// ----------------------------------------------------------------------------
// spm_cfg: configuration registers
// pattern length and the four pattern words, always ready
// ----------------------------------------------------------------------------
module spm_cfg
    import spm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spm_cfg_if.sink   cfg,
    output spm_cfg_t  regs
);

    spm_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pattern_length <= LEN_W'(1);
            regs_reg.pattern_word   <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_PATTERN_LENGTH: regs_reg.pattern_length  <= cfg.data[LEN_W-1:0];
                REG_PATTERN_WORD_0: regs_reg.pattern_word[0] <= cfg.data;
                REG_PATTERN_WORD_1: regs_reg.pattern_word[1] <= cfg.data;
                REG_PATTERN_WORD_2: regs_reg.pattern_word[2] <= cfg.data;
                REG_PATTERN_WORD_3: regs_reg.pattern_word[3] <= cfg.data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

endmodule

>>> hw/rtl/spm_cell.sv
// ----------------------------------------------------------------------------
// spm_cell: one window cell
// holds one stream byte, passes it on and records its compare result
// ----------------------------------------------------------------------------
module spm_cell
    import spm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  spm_cell_ctl_t     ctl,
    input  logic [BYTE_W-1:0] din,
    input  logic [BYTE_W-1:0] pat,
    input  logic              use_cell,
    output logic [BYTE_W-1:0] dout,
    output logic              eq
);

    logic [BYTE_W-1:0] byte_reg;
    logic              eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
            eq_reg   <= 1'b0;
        end
        else if (ctl.shift)
        begin
            // compare sees the shifted byte, the clear applies afterward
            byte_reg <= ctl.clear ? '0 : din;
            eq_reg   <= (din == pat) || !use_cell;
        end
    end

    assign dout = byte_reg;
    assign eq   = eq_reg;

endmodule

>>> hw/rtl/stream_pattern_matcher.sv
// ----------------------------------------------------------------------------
// stream_pattern_matcher: streaming naive string matcher
// byte window as a chain of compare cells, byte and match counters
// ----------------------------------------------------------------------------
//
//   port     dir   handshake      carries
//   -------  ----  -------------  -----------------------------------------
//   stream   in    valid/ready    data_byte, stream_end
//   result   out   valid/ready    match_found, match_offset, match_total
//   cfg      in    valid/ready    index, data (ready always high)
//
// one item per cycle while the result side keeps taking results; each item
// passes from accept through the cell chain, then the output register
// the cell chain compares all window bytes in parallel at accept
// reset clears the window and counters at once, no clearing pass
// a stalled result holds the output register and the compare stage; the
// stream side keeps accepting while the compare stage is free
// ----------------------------------------------------------------------------
module stream_pattern_matcher
    import spm_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    spm_in_if.sink     stream,
    spm_out_if.source  result,
    spm_cfg_if.sink    cfg
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

    // configuration
    spm_cfg_t         cfg_q;
    logic [LEN_W-1:0] len_eff;

    spm_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    // lengths above the window act as the full window
    assign len_eff = (cfg_q.pattern_length > LEN_MAX) ? LEN_MAX : cfg_q.pattern_length;

    // pipeline control
    logic in_accept;
    logic s1_adv;
    logic out_take;

    logic s1_valid_reg, s1_valid_next;
    logic s1_end_reg;
    logic [CNT_W-1:0] s1_seen_reg;

    logic out_valid_reg, out_valid_next;
    logic out_found_reg;
    logic [CNT_W-1:0] out_offset_reg;
    logic [CNT_W-1:0] out_total_reg;

    assign in_accept    = stream.valid && stream.ready;
    assign out_take     = result.valid && result.ready;
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !s1_valid_reg || s1_adv;

    // cell chain: cell 0 holds the newest byte
    spm_cell_ctl_t     cell_ctl;
    logic [BYTE_W-1:0] win      [PATTERN_MAX];
    logic [BYTE_W-1:0] cell_din [PATTERN_MAX];
    logic [BYTE_W-1:0] cell_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_use;
    logic [PATTERN_MAX-1:0] eq_vec;

    assign cell_ctl.shift = in_accept;
    assign cell_ctl.clear = stream.stream_end;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [LEN_W-1:0] sel_idx;

        if (k == 0)
        begin : g_head
            assign cell_din[k] = stream.data_byte;
        end
        else
        begin : g_body
            assign cell_din[k] = win[k-1];
        end

        // cell k lines up with pattern byte len-1-k
        assign sel_idx     = len_eff - LEN_W'(k) - LEN_W'(1);
        assign cell_use[k] = LEN_W'(k) < len_eff;
        assign cell_pat[k] = pattern_byte(cfg_q.pattern_word, sel_idx[4:0]);

        spm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .din      (cell_din[k]),
            .pat      (cell_pat[k]),
            .use_cell (cell_use[k]),
            .dout     (win[k]),
            .eq       (eq_vec[k])
        );
    end

    // byte counter, advanced at accept, cleared after an end mark
    logic [CNT_W-1:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0] seen_new;

    assign seen_new   = (bytes_reg == CNT_MAX) ? bytes_reg : bytes_reg + CNT_W'(1);
    assign bytes_next = stream.stream_end ? '0 : seen_new;

    // match decision on the registered compare bits
    logic [CNT_W-1:0] len_ext;
    logic             hit;
    logic [CNT_W-1:0] total_new;
    logic [CNT_W-1:0] offset_new;
    logic [CNT_W-1:0] matches_reg, matches_next;

    assign len_ext    = CNT_W'(len_eff);
    assign hit        = (len_eff != '0) && (&eq_vec) && (s1_seen_reg >= len_ext);
    assign total_new  = (hit && (matches_reg != CNT_MAX)) ? matches_reg + CNT_W'(1)
                                                          : matches_reg;
    assign offset_new = hit ? s1_seen_reg - len_ext : '0;
    assign matches_next = s1_end_reg ? '0 : total_new;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bytes_reg     <= '0;
            matches_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
                bytes_reg <= bytes_next;
            if (s1_adv)
                matches_reg <= matches_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_seen_reg <= seen_new;
            s1_end_reg  <= stream.stream_end;
        end
        if (s1_adv)
        begin
            out_found_reg  <= hit;
            out_offset_reg <= offset_new;
            out_total_reg  <= total_new;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.match_found  = out_found_reg;
    assign result.match_offset = out_offset_reg;
    assign result.match_total  = out_total_reg;

    // an end mark restarts the byte count
    a_end_clears_bytes : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept && stream.stream_end |=> bytes_reg == '0
    ) else $error("byte count not cleared after end mark");

    // a reported match is always counted
    a_match_counted : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv && hit |=> result.match_found && result.match_total != '0
    ) else $error("match reported with zero total");

    // no match, no offset
    a_offset_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv && !hit |=> result.match_offset == '0
    ) else $error("nonzero offset without a match");

    // the compare stage never loses an item to a new accept
    a_no_overrun : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !in_accept
    ) else $error("item accepted over a stalled compare stage");

endmodule

>>> test/spm_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spm_match_checker: result checker for the stream pattern matcher
// tracks register writes, predicts the match result of every accepted byte
// and compares it field by field with the results the block hands out
// ----------------------------------------------------------------------------
module spm_match_checker
    import spm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spm_in_if    stream,
    spm_out_if   result,
    spm_cfg_if   cfg,
    output int   mismatch_count,
    output int   results_pending
);

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] total;
    } match_result_t;

    logic [LEN_W-1:0]                 pat_len;
    logic [PAT_BYTES*BYTE_W-1:0]      pat_bits;
    logic [PAT_BYTES-1:0][BYTE_W-1:0] window;      // entry 0 newest
    logic [CNT_W-1:0]                 bytes_count;
    logic [CNT_W-1:0]                 match_count;
    match_result_t                    expected_matches[$];

    // shift one byte in and compare the tail of the window with the pattern
    function automatic match_result_t scan_byte(input logic [BYTE_W-1:0] b,
                                                input logic is_end);
        match_result_t r;
        int            span;
        logic          hit;
        span = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
        window = {window[PAT_BYTES-2:0], b};
        if (bytes_count != CNT_MAX)
            bytes_count = bytes_count + CNT_W'(1);
        hit = (span > 0) && (bytes_count >= CNT_W'(span));
        for (int j = 0; j < span; j++)
            if (pat_bits[BYTE_W*j +: BYTE_W] != window[span-1-j])
                hit = 1'b0;
        r = '0;
        if (hit)
        begin
            r.found  = 1'b1;
            r.offset = bytes_count - CNT_W'(span);
            if (match_count != CNT_MAX)
                match_count = match_count + CNT_W'(1);
        end
        r.total = match_count;
        if (is_end)
        begin
            window      = '0;
            bytes_count = '0;
            match_count = '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        match_result_t want;
        if (!rst_n)
        begin
            pat_len        = 6'd1;
            pat_bits       = '0;
            window         = '0;
            bytes_count    = '0;
            match_count    = '0;
            mismatch_count = 0;
            expected_matches.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PATTERN_LENGTH: pat_len = cfg.data[LEN_W-1:0];
                    REG_PATTERN_WORD_0: pat_bits[0*WORD_W +: WORD_W] = cfg.data;
                    REG_PATTERN_WORD_1: pat_bits[1*WORD_W +: WORD_W] = cfg.data;
                    REG_PATTERN_WORD_2: pat_bits[2*WORD_W +: WORD_W] = cfg.data;
                    REG_PATTERN_WORD_3: pat_bits[3*WORD_W +: WORD_W] = cfg.data;
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display({"%0t: result with nothing pending: ",
                                  "found %0b offset %0d total %0d"},
                                 $realtime, result.match_found, result.match_offset,
                                 result.match_total);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (result.match_found !== want.found ||
                        result.match_offset !== want.offset ||
                        result.match_total !== want.total)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: mismatch: exp found %0b offset %0d total %0d, ",
                                      "got found %0b offset %0d total %0d"},
                                     $realtime, want.found, want.offset, want.total,
                                     result.match_found, result.match_offset,
                                     result.match_total);
                        mismatch_count++;
                    end
                end
            end

            if (stream.valid && stream.ready)
                expected_matches.push_back(scan_byte(stream.data_byte, stream.stream_end));
        end
        results_pending = expected_matches.size();
    end

endmodule

>>> test/stream_pattern_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_pattern_matcher_tb: testbench for the stream pattern matcher
// directed byte runs for the stream start, a zero length and overlapping
// matches, then random phases (an oversized length among them) that embed the configured pattern
// whole and broken into byte streams, with random idling on both sides
// ----------------------------------------------------------------------------
module stream_pattern_matcher_tb;
    import spm_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int IDLE_PCT       = 38;     // idle cycles per hundred, each side
    localparam int END_PCT        = 8;      // chance of a stream end after a segment
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 75;
    localparam int BURST_PHASE    = 6;      // phase run with no idling at all
    localparam int SETTLE_CYCLES  = 8;      // settle time before the verdict, with margin

    logic                        clk;
    logic                        rst_n;
    logic                        burst;          // both sides at full rate
    logic [PAT_BYTES*BYTE_W-1:0] pat_img;        // pattern as last written
    int                          pat_span;       // bytes of it in use
    int                          mismatch_total;
    int                          results_pending;

    spm_in_if  stream_if ();
    spm_out_if result_if ();
    spm_cfg_if cfg_if ();

    stream_pattern_matcher #(
        .PATTERN_MAX (PAT_BYTES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    spm_match_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .stream          (stream_if),
        .result          (result_if),
        .cfg             (cfg_if),
        .mismatch_count  (mismatch_total),
        .results_pending (results_pending)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // result side stalls at random, except in the burst phase
    always @(posedge clk)
        result_if.ready <= burst || ($urandom_range(99) >= IDLE_PCT);

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // one register write; valid is left high for back to back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(negedge clk);
        while (!cfg_if.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // length with random upper bits, then all four pattern words
    task automatic load_pattern(input logic [LEN_W-1:0] len,
                                input logic [PAT_BYTES*BYTE_W-1:0] bits);
        logic [WORD_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        // stray write to an unused index now and then, must be dropped
        if ($urandom_range(1))
            write_reg(CFG_IDX_W'(REG_PATTERN_WORD_3 + 1 + $urandom_range(2)),
                      {$urandom, $urandom});
        write_reg(REG_PATTERN_LENGTH, len_word);
        for (int w = 0; w < PAT_WORDS; w++)
            write_reg(CFG_IDX_W'(REG_PATTERN_WORD_0 + w), bits[WORD_W*w +: WORD_W]);
        cfg_if.valid <= 1'b0;
        pat_img  = bits;
        pat_span = (len > PAT_BYTES) ? PAT_BYTES : int'(len);
    endtask

    // one stream item, after a random gap; valid stays high afterward
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_end);
        while (!burst && $urandom_range(99) < IDLE_PCT)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid      <= 1'b1;
        stream_if.data_byte  <= b;
        stream_if.stream_end <= is_end;
        @(negedge clk);
        while (!stream_if.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // stop sending and wait until every result has come back
    // every item gives a result, so an empty queue means the block is idle
    task automatic drain();
        stream_if.valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic end_roll();
        return $urandom_range(99) < END_PCT;
    endfunction

    // random pattern: free bytes, one repeated byte, short period or two symbols
    function automatic logic [PAT_BYTES*BYTE_W-1:0] make_pattern();
        logic [PAT_BYTES*BYTE_W-1:0] bits;
        logic [BYTE_W-1:0]           a;
        logic [BYTE_W-1:0]           c;
        int                          period;
        a      = BYTE_W'($urandom);
        c      = BYTE_W'($urandom);
        period = $urandom_range(3, 1);
        case ($urandom_range(3))
            0:
                for (int k = 0; k < PAT_BYTES / 4; k++)
                    bits[32*k +: 32] = $urandom;
            1:
                for (int j = 0; j < PAT_BYTES; j++)
                    bits[BYTE_W*j +: BYTE_W] = a;
            2:
                for (int j = 0; j < PAT_BYTES; j++)
                    bits[BYTE_W*j +: BYTE_W] = (j % period == 0) ? a : c;
            default:
                for (int j = 0; j < PAT_BYTES; j++)
                    bits[BYTE_W*j +: BYTE_W] = $urandom_range(1) ? a : c;
        endcase
        return bits;
    endfunction

    // stream made of segments: whole pattern, broken pattern, bytes drawn
    // from the pattern, plain noise; a stream end may close any segment
    task automatic random_phase(input int n_items);
        int                sent;
        int                kind;
        int                cnt;
        int                pick;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (pat_span > 0 && kind < 45)
            begin
                // back to back copies give overlapping matches
                for (int j = 0; j < pat_span; j++)
                    send_byte(pat_img[BYTE_W*j +: BYTE_W], (j == pat_span - 1) && end_roll());
                sent += pat_span;
            end
            else if (pat_span > 1 && kind < 60)
            begin
                // prefix, then one corrupted byte
                cnt = $urandom_range(pat_span - 1, 1);
                for (int j = 0; j < cnt; j++)
                    send_byte(pat_img[BYTE_W*j +: BYTE_W], 1'b0);
                b = pat_img[BYTE_W*cnt +: BYTE_W] ^ BYTE_W'($urandom_range(255, 1));
                send_byte(b, end_roll());
                sent += cnt + 1;
            end
            else if (kind < 85)
            begin
                cnt = $urandom_range(6, 1);
                for (int j = 0; j < cnt; j++)
                begin
                    pick = $urandom_range((pat_span > 0) ? pat_span - 1 : 0);
                    send_byte(pat_img[BYTE_W*pick +: BYTE_W], (j == cnt - 1) && end_roll());
                end
                sent += cnt;
            end
            else
            begin
                cnt = $urandom_range(3, 1);
                for (int j = 0; j < cnt; j++)
                begin
                    b = BYTE_W'($urandom);
                    send_byte(b, (j == cnt - 1) && end_roll());
                end
                sent += cnt;
            end
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] len;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        burst                = 1'b0;
        stream_if.valid      = 1'b0;
        stream_if.data_byte  = '0;
        stream_if.stream_end = 1'b0;
        result_if.ready      = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = REG_PATTERN_LENGTH;
        cfg_if.data          = '0;
        pat_img              = '0;
        pat_span             = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one byte of zero; stream end then restart at offset 0
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        drain();

        // every unused index gets a write, then a length of zero hidden
        // under all-ones upper bits: nothing may match
        for (int i = REG_PATTERN_WORD_3 + 1; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0);
        cfg_if.valid <= 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // three zero bytes: no match before three bytes of the current
        // stream, even though the cleared window already holds zeros
        load_pattern(6'd3, '0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // overlapping matches of a self-overlapping pattern
        load_pattern(6'd3, {{(PAT_BYTES-3)*BYTE_W{1'b0}}, 8'h41, 8'h42, 8'h41});
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b1);
        drain();

        // random phases, extremes of the length first; length above the
        // window size acts as the full window
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       len = 6'd1;
                1:       len = LEN_W'(PAT_BYTES);
                2:       len = '1;
                3:       len = '0;
                default:
                    len = $urandom_range(1) ? LEN_W'($urandom_range(8, 1))
                                            : LEN_W'($urandom_range(63, 1));
            endcase
            load_pattern(len, make_pattern());
            burst <= (p == BURST_PHASE);
            random_phase(PHASE_ITEMS);
            drain();
        end
        burst <= 1'b0;

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
